/* design/lpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  // Fixed field widths of the channels and registers.
  localparam int SENSOR_W   = 11;
  localparam int POS_W      = 13;
  localparam int DUTY_W     = 8;
  localparam int GAIN_W     = 16;
  localparam int SHIFT_W    = 4;
  localparam int ERR_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_PORTS  = 8;

  // Position scale and reset values.
  localparam int POS_STEP    = 1000;
  localparam int POS_MAX     = 8000;
  localparam int POS_RESET   = 4500;
  localparam int FLOOR_RESET = 200;
  localparam int MAX_RESET   = 255;
  localparam int START_RESET = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DUTY     = 3'd0,
    REG_START_SPEED   = 3'd1,
    REG_PROP_GAIN     = 3'd2,
    REG_DERIV_GAIN    = 3'd3,
    REG_GAIN_SHIFT    = 3'd4,
    REG_NOISE_FLOOR   = 3'd5,
    REG_CENTRE_TARGET = 3'd6
  } lpd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_SHIFT,
    ST_CLAMP
  } lpd_state_t;

  typedef struct packed {
    logic sum_en;
    logic div_start;
    logic hold_en;
    logic mul_en;
    logic shift_en;
    logic commit;
  } lpd_ctrl_t;

endpackage

`default_nettype wire

/* design/lpd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// One sensor lane: saturate, apply the noise floor and weight the reading.
module lpd_lane
  import lpd_pkg::*;
#(
  parameter int WEIGHT      = 1000,
  parameter int READING_MAX = 2000,
  parameter int NUM_W       = 27
) (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic [SENSOR_W-1:0] noise_floor,
  input  wire logic [SENSOR_W-1:0] reading,
  output logic      [SENSOR_W-1:0] level,
  output logic      [NUM_W-1:0]    product
);

  localparam logic [SENSOR_W-1:0] SAT      = SENSOR_W'(READING_MAX);
  localparam logic [NUM_W-1:0]    WEIGHT_V = NUM_W'(WEIGHT);

  logic [SENSOR_W-1:0] sat_val;
  logic [SENSOR_W-1:0] level_next;
  logic [NUM_W-1:0]    product_next;

  always_comb begin
    sat_val      = (reading > SAT) ? SAT : reading;
    level_next   = (sat_val < noise_floor) ? '0 : sat_val;
    product_next = NUM_W'(level_next) * WEIGHT_V;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      level   <= level_next;
      product <= product_next;
    end
  end

endmodule

`default_nettype wire

/* design/lpd_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// Adds up what the lanes found: weighted numerator and plain reading sum.
module lpd_merge
  import lpd_pkg::*;
#(
  parameter int N     = 8,
  parameter int NUM_W = 27,
  parameter int DEN_W = 14
) (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic [SENSOR_W-1:0] level   [N],
  input  wire logic [NUM_W-1:0]    product [N],
  output logic      [NUM_W-1:0]    num,
  output logic      [DEN_W-1:0]    den
);

  logic [NUM_W-1:0] num_next;
  logic [DEN_W-1:0] den_next;

  always_comb begin
    num_next = '0;
    den_next = '0;
    for (int i = 0; i < N; i++) begin
      num_next = num_next + product[i];
      den_next = den_next + DEN_W'(level[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num <= num_next;
      den <= den_next;
    end
  end

endmodule

`default_nettype wire

/* design/lpd_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The numerator register
// shifts out dividend bits and shifts in quotient bits.
module lpd_div
  import lpd_pkg::*;
#(
  parameter int NUM_W = 27,
  parameter int DEN_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic                  done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem, quo[NUM_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(NUM_W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= num;
      divisor <= den;
    end else if (cnt != '0) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

/* design/lpd_pd.sv */
`timescale 1ns / 1ps
`default_nettype none

// PD term, soft-start ramp and duty clamping over three steps.
module lpd_pd
  import lpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lpd_ctrl_t         ctrl,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [POS_W-1:0]  centre,
  input  wire logic [GAIN_W-1:0] prop_gain,
  input  wire logic [GAIN_W-1:0] deriv_gain,
  input  wire logic [SHIFT_W-1:0] gain_shift,
  input  wire logic [DUTY_W-1:0] base_duty,
  input  wire logic [DUTY_W-1:0] start_speed,
  input  wire logic              ramp_load,
  output logic      [DUTY_W-1:0] left,
  output logic      [DUTY_W-1:0] right
);

  logic signed [ERR_W-1:0]  err_next;
  logic signed [ERR_W:0]    diff;
  logic signed [GAIN_W:0]   kp_s;
  logic signed [GAIN_W:0]   kd_s;
  logic signed [30:0]       p_next;
  logic signed [31:0]       d_next;
  logic signed [32:0]       pd_sum;
  logic signed [34:0]       left_raw;
  logic signed [34:0]       right_raw;
  logic signed [34:0]       limit_s;
  logic        [DUTY_W-1:0] limit;

  // Registers
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [30:0]       p_term;
  logic signed [31:0]       d_term;
  logic signed [32:0]       term;
  logic        [DUTY_W-1:0] ramp;

  always_comb begin
    err_next = $signed({1'b0, position}) - $signed({1'b0, centre});
    kp_s     = $signed({1'b0, prop_gain});
    kd_s     = $signed({1'b0, deriv_gain});
    diff     = err_next - prev_err;
    p_next   = kp_s * err_next;
    d_next   = kd_s * diff;
    pd_sum   = p_term + d_term;
  end

  // The ramp caps the duties until it has climbed to the base duty.
  always_comb begin
    limit     = (ramp < base_duty) ? ramp : base_duty;
    limit_s   = $signed({1'b0, limit});
    left_raw  = $signed({1'b0, base_duty}) + term;
    right_raw = $signed({1'b0, base_duty}) - term;
    if (left_raw < 0) begin
      left = '0;
    end else if (left_raw > limit_s) begin
      left = limit;
    end else begin
      left = left_raw[DUTY_W-1:0];
    end
    if (right_raw < 0) begin
      right = '0;
    end else if (right_raw > limit_s) begin
      right = limit;
    end else begin
      right = right_raw[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      err    <= err_next;
      p_term <= p_next;
      d_term <= d_next;
    end
    if (ctrl.shift_en) begin
      term <= pd_sum >>> gain_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      ramp     <= DUTY_W'(START_RESET);
    end else begin
      if (ctrl.shift_en) begin
        prev_err <= err;
      end
      if (ramp_load) begin
        ramp <= start_speed;
      end else if (ctrl.commit && (ramp < base_duty)) begin
        ramp <= ramp + DUTY_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/line_position_pd_drive_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, sensor_0 .. sensor_7  | sink
// out     | out_valid, out_ready, left_duty,          | source
//         | right_duty, line_position                 |
// cfg     | cfg_we, cfg_index, cfg_data               | sink
//
// A frame passes the sequencer states SUM, LOAD, DIV, MUL, SHIFT and CLAMP,
// with the bit-serial divider in DIV taking longest; the next frame is taken
// only when the sequencer is back in IDLE: one frame is in flight at a time.
// Reset is synchronous and returns registers, position history and ramp to
// their defaults. A new frame is taken while the last result still waits on
// out_ready; a stalled output holds the final step until it is taken.

module line_position_pd_drive_core
  import lpd_pkg::*;
#(
  parameter int NUM_SENSORS = 8,
  parameter int READING_MAX = 2000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SENSOR_W-1:0]   sensor_0,
  input  wire logic [SENSOR_W-1:0]   sensor_1,
  input  wire logic [SENSOR_W-1:0]   sensor_2,
  input  wire logic [SENSOR_W-1:0]   sensor_3,
  input  wire logic [SENSOR_W-1:0]   sensor_4,
  input  wire logic [SENSOR_W-1:0]   sensor_5,
  input  wire logic [SENSOR_W-1:0]   sensor_6,
  input  wire logic [SENSOR_W-1:0]   sensor_7,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [DUTY_W-1:0]     left_duty,
  output logic      [DUTY_W-1:0]     right_duty,
  output logic      [POS_W-1:0]      line_position,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Worst-case weighted sum and reading sum set the datapath widths.
  localparam int NUM_W =
    $clog2(POS_STEP * NUM_SENSORS * (NUM_SENSORS + 1) / 2 * READING_MAX + 1);
  localparam int DEN_W = $clog2(NUM_SENSORS * READING_MAX + 1);

  // Configuration registers.
  logic [DUTY_W-1:0]   base_duty;
  logic [GAIN_W-1:0]   prop_gain;
  logic [GAIN_W-1:0]   deriv_gain;
  logic [SHIFT_W-1:0]  gain_shift;
  logic [SENSOR_W-1:0] noise_floor;
  logic [POS_W-1:0]    centre_target;

  logic [POS_W-1:0]    held_position;
  lpd_state_t          state;
  lpd_state_t          state_next;
  lpd_ctrl_t           ctrl;

  logic                in_accept;
  logic                ramp_load;
  logic [SENSOR_W-1:0] sensor_arr [NUM_PORTS];
  logic [SENSOR_W-1:0] lane_level [NUM_SENSORS];
  logic [NUM_W-1:0]    lane_prod  [NUM_SENSORS];
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [NUM_W-1:0]    quo;
  logic                div_done;
  logic [DUTY_W-1:0]   left_next;
  logic [DUTY_W-1:0]   right_next;

  assign in_accept = in_valid && in_ready;

  assign sensor_arr[0] = sensor_0;
  assign sensor_arr[1] = sensor_1;
  assign sensor_arr[2] = sensor_2;
  assign sensor_arr[3] = sensor_3;
  assign sensor_arr[4] = sensor_4;
  assign sensor_arr[5] = sensor_5;
  assign sensor_arr[6] = sensor_6;
  assign sensor_arr[7] = sensor_7;

  // Writing start_speed also restarts the soft-start ramp from that value.
  assign ramp_load = cfg_we && (cfg_index == REG_START_SPEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_duty     <= DUTY_W'(MAX_RESET);
      prop_gain     <= '0;
      deriv_gain    <= '0;
      gain_shift    <= '0;
      noise_floor   <= SENSOR_W'(FLOOR_RESET);
      centre_target <= POS_W'(POS_RESET);
    end else if (cfg_we) begin
      case (lpd_reg_t'(cfg_index))
        REG_BASE_DUTY:     base_duty     <= cfg_data[DUTY_W-1:0];
        // The start speed has no register of its own; a write only
        // reloads the ramp.
        REG_START_SPEED:   ;
        REG_PROP_GAIN:     prop_gain     <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:    deriv_gain    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_SHIFT:    gain_shift    <= cfg_data[SHIFT_W-1:0];
        REG_NOISE_FLOOR:   noise_floor   <= cfg_data[SENSOR_W-1:0];
        REG_CENTRE_TARGET: centre_target <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Each lane captures its reading on the accepting edge and weights it by
  // its position along the bar.
  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lpd_lane #(
      .WEIGHT      (POS_STEP * (g + 1)),
      .READING_MAX (READING_MAX),
      .NUM_W       (NUM_W)
    ) u_lane (
      .clk         (clk),
      .load        (in_accept),
      .noise_floor (noise_floor),
      .reading     (sensor_arr[g]),
      .level       (lane_level[g]),
      .product     (lane_prod[g])
    );
  end

  lpd_merge #(
    .N     (NUM_SENSORS),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_merge (
    .clk     (clk),
    .load    (ctrl.sum_en),
    .level   (lane_level),
    .product (lane_prod),
    .num     (num),
    .den     (den)
  );

  lpd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  // A frame with no reading at or above the floor keeps the last position.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_position <= POS_W'(POS_RESET);
    end else if (ctrl.hold_en) begin
      held_position <= quo[POS_W-1:0];
    end
  end

  lpd_pd u_pd (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .position    (held_position),
    .centre      (centre_target),
    .prop_gain   (prop_gain),
    .deriv_gain  (deriv_gain),
    .gain_shift  (gain_shift),
    .base_duty   (base_duty),
    .start_speed (cfg_data[DUTY_W-1:0]),
    .ramp_load   (ramp_load),
    .left        (left_next),
    .right       (right_next)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SUM;
      ST_SUM:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_CLAMP;
      ST_CLAMP: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE:  in_ready       = 1'b1;
      ST_SUM:   ctrl.sum_en    = 1'b1;
      ST_LOAD:  ctrl.div_start = 1'b1;
      ST_DIV:   ctrl.hold_en   = div_done && (den != '0);
      ST_MUL:   ctrl.mul_en    = 1'b1;
      ST_SHIFT: ctrl.shift_en  = 1'b1;
      ST_CLAMP: ctrl.commit    = !out_valid || out_ready;
      default:  ctrl           = '0;
    endcase
  end

  // Output register: the finished beat waits here while the next frame runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      left_duty     <= left_next;
      right_duty    <= right_next;
      line_position <= held_position;
    end
  end

endmodule

`default_nettype wire

/* design/lpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpd_checker
  import lpd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DUTY_W-1:0]     left_duty,
  input wire logic [DUTY_W-1:0]     right_duty,
  input wire logic [POS_W-1:0]      line_position
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_duty)
      && $stable(right_duty) && $stable(line_position))
    else $error("result beat changed while stalled");

  // A frame occupies the datapath, so the input closes after a beat.
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame taken while one is in flight");

  // Issuing a result frees the datapath for the next frame.
  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("input not reopened after a result");

  // The centroid never leaves the bar.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_position <= POS_W'(POS_MAX))
    else $error("line position out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind line_position_pd_drive_core lpd_checker u_lpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .left_duty     (left_duty),
  .right_duty    (right_duty),
  .line_position (line_position)
);

`default_nettype wire

/* dv/tb_line_position_pd_drive_core.sv */
`timescale 1ns / 1ps

module tb_line_position_pd_drive_core;
  import lpd_pkg::*;

  // The block is built with its default sizes. The prediction below uses
  // the same figures.
  localparam int NUM_SENSORS = 8;
  localparam int READING_MAX = 2000;

  // Cycles with work outstanding but no beat on either channel before the
  // run is declared hung. This is far longer than one frame takes, so it is
  // generous even with a long run of output stalls.
  localparam int STALL_LIMIT = 2000;

  // Quiet cycles after the last result, to catch a stray extra result.
  localparam int TAIL_CYCLES = 50;

  // Register index with no register behind it. A write there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Percentage of cycles in which either side holds off.
  localparam int IDLE_PCT = 34;

  typedef logic [NUM_PORTS-1:0][SENSOR_W-1:0] frame_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
    logic [POS_W-1:0]  pos;
  } drive_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  frame_t                bus_frame = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DUTY_W-1:0]     left_duty;
  logic [DUTY_W-1:0]     right_duty;
  logic [POS_W-1:0]      line_position;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Frames waiting to be driven, and the drive commands predicted for frames
  // already accepted, oldest first.
  frame_t frames_pending[$];
  drive_t drive_expected[$];

  // Turns off idling on both channels for one whole phase.
  logic steady_flow = 1'b0;

  int mismatch_count = 0;
  int idle_cycles = 0;

  // Our copy of the register file, at its reset values.
  int cfg_max    = MAX_RESET;
  int cfg_start  = START_RESET;
  int cfg_prop   = 0;
  int cfg_deriv  = 0;
  int cfg_shift  = 0;
  int cfg_floor  = FLOOR_RESET;
  int cfg_centre = POS_RESET;

  // Our copy of the controller history: last known line position, last
  // error, and where the soft-start ramp currently stands.
  int held_pos = POS_RESET;
  int prev_err = 0;
  int ramp     = START_RESET;

  line_position_pd_drive_core #(
    .NUM_SENSORS(NUM_SENSORS),
    .READING_MAX(READING_MAX)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sensor_0     (bus_frame[0]),
    .sensor_1     (bus_frame[1]),
    .sensor_2     (bus_frame[2]),
    .sensor_3     (bus_frame[3]),
    .sensor_4     (bus_frame[4]),
    .sensor_5     (bus_frame[5]),
    .sensor_6     (bus_frame[6]),
    .sensor_7     (bus_frame[7]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_duty    (left_duty),
    .right_duty   (right_duty),
    .line_position(line_position),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Duties saturate at zero and at the current ceiling; they never wrap.
  function automatic logic [DUTY_W-1:0] clamp_duty(longint level, int ceiling);
    if (level < 0) return '0;
    if (level > ceiling) return ceiling[DUTY_W-1:0];
    return level[DUTY_W-1:0];
  endfunction

  // Works out the drive command for one accepted frame and advances the
  // controller history, exactly once per frame and in acceptance order.
  function automatic drive_t compute_drive(frame_t f);
    longint weighted;
    longint total;
    longint pd;
    longint turn;
    int     reading;
    int     err;
    int     ceiling;
    int     i;
    drive_t d;
    weighted = 0;
    total = 0;
    for (i = 0; i < NUM_SENSORS; i++) begin
      reading = f[i];
      // Saturate first, then drop anything under the noise floor.
      if (reading > READING_MAX) reading = READING_MAX;
      if (reading < cfg_floor) reading = 0;
      weighted += longint'(POS_STEP) * (i + 1) * reading;
      total += reading;
    end
    // With no line seen at all the last position stands.
    if (total != 0) held_pos = int'(weighted / total);
    err = held_pos - cfg_centre;
    pd = longint'(cfg_prop) * err + longint'(cfg_deriv) * (err - prev_err);
    prev_err = err;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    turn = pd >>> cfg_shift;
    // While the ramp is below the base speed it caps both wheels and climbs
    // by one per frame; after that the base speed is the cap.
    if (ramp < cfg_max) begin
      ceiling = ramp;
      ramp = (ramp + 1) & 8'hFF;
    end else begin
      ceiling = cfg_max;
    end
    d.left  = clamp_duty(cfg_max + turn, ceiling);
    d.right = clamp_duty(cfg_max - turn, ceiling);
    d.pos   = held_pos[POS_W-1:0];
    return d;
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    if (mismatch_count < 10) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
    mismatch_count++;
  endtask

  // One register write. Our copy is updated at once; this is safe because
  // writes only happen while no frame is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_BASE_DUTY:     cfg_max = value & 8'hFF;
      REG_START_SPEED: begin
        // Loading the start speed also restarts the ramp from there.
        cfg_start = value & 8'hFF;
        ramp = cfg_start;
      end
      REG_PROP_GAIN:     cfg_prop = value & 16'hFFFF;
      REG_DERIV_GAIN:    cfg_deriv = value & 16'hFFFF;
      REG_GAIN_SHIFT:    cfg_shift = value & 4'hF;
      REG_NOISE_FLOOR:   cfg_floor = value & 11'h7FF;
      REG_CENTRE_TARGET: cfg_centre = value & 13'h1FFF;
      default: ;
    endcase
  endtask

  // Rewrites every register, with a junk write to the unused index first.
  // Write enable stays high across the burst and drops once at the end.
  task automatic load_settings(int top, int launch, int kp, int kd,
                               int shift_amt, int floor_lvl, int centre);
    write_reg(REG_SPARE, $urandom_range(16'hFFFF));
    write_reg(REG_BASE_DUTY, top);
    write_reg(REG_START_SPEED, launch);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_GAIN_SHIFT, shift_amt);
    write_reg(REG_NOISE_FLOOR, floor_lvl);
    write_reg(REG_CENTRE_TARGET, centre);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Blocks until every queued frame has been accepted and answered, which
  // leaves the block idle and ready for register writes.
  task automatic settle();
    while (frames_pending.size() != 0 || in_valid || drive_expected.size() != 0)
      @(negedge clk);
  endtask

  function automatic frame_t lone_frame(int idx, int value);
    frame_t f;
    f = '0;
    f[idx] = value[SENSOR_W-1:0];
    return f;
  endfunction

  // Most frames look like a dark line under the array: a peak with sloped
  // shoulders and a little background. The rest are raw noise, near-floor
  // and blank frames that exercise the hold path, and saturated frames.
  function automatic frame_t random_frame();
    frame_t f;
    int kind;
    int mid;
    int peak;
    int spread;
    int gap;
    int level;
    int i;
    f = '0;
    kind = $urandom_range(99);
    if (kind < 65) begin
      mid = $urandom_range(7000);
      peak = $urandom_range(800, 2047);
      spread = $urandom_range(400, 2000);
      for (i = 0; i < NUM_PORTS; i++) begin
        gap = 1000 * i - mid;
        if (gap < 0) gap = -gap;
        level = (gap >= spread) ? 0 : peak - peak * gap / spread;
        level += $urandom_range(120);
        if (level > 2047) level = 2047;
        f[i] = level[SENSOR_W-1:0];
      end
    end else if (kind < 80) begin
      for (i = 0; i < NUM_PORTS; i++) f[i] = $urandom_range(2047);
    end else if (kind < 90) begin
      for (i = 0; i < NUM_PORTS; i++) f[i] = $urandom_range(250);
    end else if (kind >= 95) begin
      for (i = 0; i < NUM_PORTS; i++) f[i] = $urandom_range(1900, 2047);
    end
    return f;
  endfunction

  // Input driver. A beat is predicted at the edge where it is taken; the
  // payload is then replaced or valid dropped, each with one assignment.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) drive_expected.push_back(compute_drive(bus_frame));
      if (!in_valid || in_ready) begin
        if (frames_pending.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          bus_frame <= frames_pending.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Every result beat is matched against the oldest
  // prediction, field by field; ready is thrown at random for backpressure.
  always @(posedge clk) begin : result_check
    drive_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          flag_mismatch("result beat with no frame outstanding, count", 0, 1);
        end else begin
          want = drive_expected.pop_front();
          if (left_duty !== want.left)
            flag_mismatch("left_duty", want.left, left_duty);
          if (right_duty !== want.right)
            flag_mismatch("right_duty", want.right, right_duty);
          if (line_position !== want.pos)
            flag_mismatch("line_position", want.pos, line_position);
        end
      end
      out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: only counts while something is still owed by either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (frames_pending.size() == 0 && !in_valid && drive_expected.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int top;
    int launch;
    int floor_lvl;
    int centre;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero gains, ramp climbing from zero. Covers the hold
    // on a blank frame, saturation, both ends of the array, readings just
    // under and exactly at the noise floor.
    frames_pending.push_back('0);
    frames_pending.push_back({NUM_PORTS{11'd2047}});
    frames_pending.push_back(lone_frame(0, 2000));
    frames_pending.push_back(lone_frame(7, 2047));
    frames_pending.push_back({NUM_PORTS{11'd199}});
    frames_pending.push_back(lone_frame(3, 200));
    frames_pending.push_back({11'd0, 11'd0, 11'd0, 11'd0, 11'd1023, 11'd1024, 11'd0, 11'd0});
    settle();

    // Upper extremes: full gains, no shift, no floor, setpoint past the
    // array edge, ramp already at the base speed. Both duties slam to a rail.
    load_settings(255, 255, 16'hFFFF, 16'hFFFF, 0, 0, 13'h1FFF);
    frames_pending.push_back('0);
    frames_pending.push_back(lone_frame(0, 1));
    frames_pending.push_back(lone_frame(7, 2047));
    frames_pending.push_back({NUM_PORTS{11'h555}});
    frames_pending.push_back({NUM_PORTS{11'h2AA}});
    frames_pending.push_back(lone_frame(4, 2001));
    settle();

    // Lower extremes: zero speed, zero gains, widest shift, a floor above
    // any saturated reading so every frame holds, setpoint at zero.
    load_settings(0, 0, 0, 0, 15, 2047, 0);
    frames_pending.push_back({NUM_PORTS{11'd2047}});
    frames_pending.push_back(lone_frame(2, 1500));
    frames_pending.push_back('0);
    settle();

    // Small negative sums under a wide shift must floor to minus one, with
    // the ramp finishing its climb a few frames in.
    load_settings(128, 124, 3, 1, 15, 1, 13'h1FFF);
    frames_pending.push_back(lone_frame(1, 1));
    frames_pending.push_back(lone_frame(6, 900));
    frames_pending.push_back({NUM_PORTS{11'd1}});
    frames_pending.push_back('0);
    settle();

    // Random phases, each with fresh settings. Gains span many magnitudes
    // so that both clamped and mid-range duties show up.
    for (phase = 0; phase < 12; phase++) begin
      if ($urandom_range(5) == 0) top = $urandom_range(1) ? 255 : 0;
      else top = $urandom_range(255);
      launch = $urandom_range(1) ? top : $urandom_range(255);
      floor_lvl = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(400);
      centre = ($urandom_range(3) == 0) ? POS_RESET : $urandom_range(13'h1FFF);
      load_settings(top, launch,
                    $urandom_range((1 << $urandom_range(16)) - 1),
                    $urandom_range((1 << $urandom_range(16)) - 1),
                    $urandom_range(15), floor_lvl, centre);
      // One phase runs with both sides always willing.
      steady_flow = (phase == 4);
      n = $urandom_range(55, 90);
      repeat (n) frames_pending.push_back(random_frame());
      settle();
      steady_flow = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && drive_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
